[design/four_momentum_accumulate_kinematics_unit_assert.svh]
// Assertion macros for the four-momentum accumulate kinematics unit.
`ifndef FOUR_MOMENTUM_ACCUMULATE_KINEMATICS_UNIT_ASSERT_SVH
`define FOUR_MOMENTUM_ACCUMULATE_KINEMATICS_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FMK_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define FMK_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[design/fmk_pkg.sv]
// Shared types and constants of the four-momentum kinematics unit.
`timescale 1ns / 1ps
package fmk_pkg;

  localparam int unsigned CordicW = 66;
  localparam int unsigned AngleW  = 24;
  localparam logic signed [19:0] HalfLn2Q16 = 20'sd22713;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_CIRC,
    ST_HYP,
    ST_FINISH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic circ_mode;
    logic [4:0] shift;
  } cordic_ctl_t;

  function automatic logic [AngleW-1:0] circ_angle(input logic [4:0] i);
    logic [AngleW-1:0] r;
    begin
      unique case (i)
        5'd0: r = 24'd262144;  5'd1: r = 24'd154753; 5'd2: r = 24'd81767;
        5'd3: r = 24'd41506;   5'd4: r = 24'd20834;  5'd5: r = 24'd10427;
        5'd6: r = 24'd5215;    5'd7: r = 24'd2608;   5'd8: r = 24'd1304;
        5'd9: r = 24'd652;     5'd10: r = 24'd326;   5'd11: r = 24'd163;
        5'd12: r = 24'd81;     5'd13: r = 24'd41;    5'd14: r = 24'd20;
        5'd15: r = 24'd10;     5'd16: r = 24'd5;     5'd17: r = 24'd3;
        5'd18: r = 24'd1;      5'd19: r = 24'd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [AngleW-1:0] hyp_angle(input logic [4:0] i);
    logic [AngleW-1:0] r;
    begin
      unique case (i)
        5'd1: r = 24'd35999;  5'd2: r = 24'd16739;  5'd3: r = 24'd8235;
        5'd4: r = 24'd4101;   5'd5: r = 24'd2049;   5'd6: r = 24'd1024;
        5'd7: r = 24'd512;    5'd8: r = 24'd256;    5'd9: r = 24'd128;
        5'd10: r = 24'd64;    5'd11: r = 24'd32;    5'd12: r = 24'd16;
        5'd13: r = 24'd8;     5'd14: r = 24'd4;     5'd15: r = 24'd2;
        5'd16: r = 24'd1;     5'd17: r = 24'd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

[design/fmk_cordic_unit.sv]
// Shared shift-add CORDIC micro-rotation unit, one step per cycle while step_i is high.
`timescale 1ns / 1ps
module fmk_cordic_unit (
  input  logic                                  clk_i,
  input  logic                                  load_i,
  input  logic                                  step_i,
  input  fmk_pkg::cordic_ctl_t                  ctl_i,
  input  logic signed [fmk_pkg::CordicW-1:0]    x_init_i,
  input  logic signed [fmk_pkg::CordicW-1:0]    y_init_i,
  output logic signed [fmk_pkg::AngleW+1:0]     angle_o
);
  import fmk_pkg::*;

  logic signed [CordicW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [AngleW+1:0] z_q, z_d, ang;
  logic dir_pos;

  always_comb begin
    xs = x_q >>> ctl_i.shift;
    ys = y_q >>> ctl_i.shift;
    dir_pos = ~y_q[CordicW-1];
    ang = ctl_i.circ_mode ? $signed({2'b00, circ_angle(ctl_i.shift)})
                          : $signed({2'b00, hyp_angle(ctl_i.shift)});
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (load_i) begin
      x_d = x_init_i;
      y_d = y_init_i;
      z_d = '0;
    end else if (step_i) begin
      if (ctl_i.circ_mode) begin
        x_d = dir_pos ? x_q + ys : x_q - ys;
      end else begin
        x_d = dir_pos ? x_q - ys : x_q + ys;
      end
      y_d = dir_pos ? y_q - xs : y_q + xs;
      z_d = dir_pos ? z_q + ang : z_q - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign angle_o = z_q;
endmodule

[design/four_momentum_accumulate_kinematics_unit.sv]
// Top level: four-momentum accumulator with azimuth and rapidity readout.
//
//  channel   direction  payload
//  s_axis    in         tdata: cmd, in_px, in_py, in_pz, in_energy
//  m_axis    out        tdata: sums, transverse_sq, azimuth, rapidity, flags
//
// From its transfer to the earliest next one, an item passes through a setup step,
// the circular pass plus a reload step, the hyperbolic pass with indices 4 and 13
// run twice, a finish and an output step (ST_NORM, ST_CIRC, ST_HYP, ST_FINISH, ST_OUT).
// The single shift-add CORDIC unit serves both passes in turn; without a valid rapidity
// the hyperbolic pass is skipped.
// rst_ni clears the sums to zero and returns the sequencer to idle.
// The input is not ready while an item is in work; the result register
// holds its transfer until m_axis_tready is high, and the next item may be
// taken in that same cycle.
`timescale 1ns / 1ps
`include "four_momentum_accumulate_kinematics_unit_assert.svh"
module four_momentum_accumulate_kinematics_unit #(
  parameter int unsigned INPUT_BITS   = 24,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // From bit 0: cmd, in_px, in_py, in_pz, in_energy, zero fill.
  input  logic [((4*INPUT_BITS+1+7)/8)*8-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // From bit 0: sum_x, sum_y, sum_z, sum_energy, transverse_sq, azimuth,
  // rapidity_out, rapidity_ok, saturated.
  output logic [223:0]              m_axis_tdata
);
  import fmk_pkg::*;

  localparam int unsigned Steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       rep_q, rep_d;

  logic signed [31:0] ax_q, ay_q, az_q, ae_q;
  logic signed [INPUT_BITS-1:0] px, py, pz, pe;
  logic signed [33:0] sx, sy, sz, se;
  logic signed [31:0] nx, ny, nz, ne;
  logic sat_x, sat_y, sat_z, sat_e, accept;

  assign px = s_axis_tdata[INPUT_BITS:1];
  assign py = s_axis_tdata[2*INPUT_BITS:INPUT_BITS+1];
  assign pz = s_axis_tdata[3*INPUT_BITS:2*INPUT_BITS+1];
  assign pe = s_axis_tdata[4*INPUT_BITS:3*INPUT_BITS+1];

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v,
                                               output logic f);
    begin
      f = (v > 34'sd2147483647) || (v < -34'sd2147483648);
      if (v > 34'sd2147483647) return 32'sh7fffffff;
      if (v < -34'sd2147483648) return 32'sh80000000;
      return v[31:0];
    end
  endfunction

  always_comb begin
    sx = 34'(ax_q) + 34'(px);
    sy = 34'(ay_q) + 34'(py);
    sz = 34'(az_q) + 34'(pz);
    se = 34'(ae_q) + 34'(pe);
    nx = sat34(sx, sat_x);
    ny = sat34(sy, sat_y);
    nz = sat34(sz, sat_z);
    ne = sat34(se, sat_e);
    if (!s_axis_tdata[0]) begin
      nx = 32'(px); ny = 32'(py); nz = 32'(pz); ne = 32'(pe);
      sat_x = 1'b0; sat_y = 1'b0; sat_z = 1'b0; sat_e = 1'b0;
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  // Result register and derived values.
  logic sat_q, ok_q, out_v_q;
  logic [62:0] tsq_q;
  logic [15:0] az_out_q;
  logic [14:0] rap_q;
  logic [5:0] ka_q, kb_q;
  logic signed [41:0] ma_q, mb_q;

  logic [31:0] ux, uy;
  logic [63:0] sq_x_q, sq_y_q;
  logic signed [32:0] a_sum, b_dif;
  logic ok_c;

  assign ux = ax_q[31] ? 32'(-ax_q) : ax_q;
  assign uy = ay_q[31] ? 32'(-ay_q) : ay_q;
  assign a_sum = 33'(ae_q) + 33'(az_q);
  assign b_dif = 33'(ae_q) - 33'(az_q);
  assign ok_c = (ae_q > az_q) && (a_sum > 33'sd0);

  function automatic logic [5:0] msb33(input logic [32:0] v);
    logic [5:0] k;
    begin
      k = '0;
      for (int i = 0; i < 33; i++) if (v[i]) k = 6'(i);
      return k;
    end
  endfunction

  // CORDIC control.
  cordic_ctl_t ctl;
  logic cl_load, cl_step;
  logic signed [CordicW-1:0] xi, yi;
  logic signed [AngleW+1:0] z_ang;

  fmk_cordic_unit u_cordic (
    .clk_i   (clk_i),
    .load_i  (cl_load),
    .step_i  (cl_step),
    .ctl_i   (ctl),
    .x_init_i(xi),
    .y_init_i(yi),
    .angle_o (z_ang)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    rep_d = rep_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_NORM;
      ST_NORM: begin state_d = ST_CIRC; cnt_d = '0; end
      ST_CIRC: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(Steps)) begin
          state_d = ok_q ? ST_HYP : ST_FINISH;
          cnt_d = 5'd1;
          rep_d = 1'b0;
        end
      end
      ST_HYP: begin
        if ((cnt_q == 5'd4 || cnt_q == 5'd13) && !rep_q) begin
          rep_d = 1'b1;
        end else begin
          rep_d = 1'b0;
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == 5'(Steps)) state_d = ST_FINISH;
        end
      end
      ST_FINISH: state_d = ST_OUT;
      ST_OUT: if (m_axis_tready) state_d = accept ? ST_NORM : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE) || (state_q == ST_OUT && m_axis_tready);
    cl_load = 1'b0;
    cl_step = 1'b0;
    ctl.circ_mode = 1'b1;
    ctl.shift = cnt_q;
    xi = '0;
    yi = '0;
    unique case (state_q)
      ST_NORM: begin
        cl_load = 1'b1;
        xi = $signed({10'd0, ux, 24'd0});
        yi = $signed({10'd0, uy, 24'd0});
      end
      ST_CIRC: begin
        // The extra cycle after the last circular step reloads the unit when the rapidity is valid.
        cl_step = (cnt_q != 5'(Steps));
        cl_load = (cnt_q == 5'(Steps)) && ok_q;
        xi = 66'(ma_q) + 66'(mb_q);
        yi = 66'(ma_q) - 66'(mb_q);
      end
      ST_HYP: begin
        cl_step = 1'b1;
        ctl.circ_mode = 1'b0;
      end
      default: ;
    endcase
  end

  logic signed [AngleW+1:0] circ_z_q;
  logic signed [31:0] t_full, t_sh;
  logic [16:0] a_val;
  logic signed [16:0] a_az;
  logic [15:0] az_calc;

  always_comb begin
    a_az = '0;
    t_sh = 32'(circ_z_q + 26'sd16) >>> 5;
    if (t_sh < 0) a_val = '0;
    else if (t_sh > 32'sd16384) a_val = 17'd16384;
    else a_val = t_sh[16:0];
    if (ax_q == 0 && ay_q == 0) az_calc = '0;
    else if (ax_q == 0) az_calc = ay_q[31] ? 16'hc000 : 16'h4000;
    else if (!ax_q[31]) begin
      a_az = $signed(a_val);
      az_calc = ay_q[31] ? 16'(-a_az) : 16'(a_az);
    end else begin
      a_az = $signed(17'd32768 - a_val);
      az_calc = ay_q[31] ? 16'(-a_az) : 16'(a_az);
    end
    t_full = $signed(32'($signed(7'(ka_q) - 7'(kb_q)))) * 32'(HalfLn2Q16)
             + 32'(z_ang);
    t_full = (t_full + 32'sd32) >>> 6;
    if (t_full > 32'sd12288) t_full = 32'sd12288;
    if (t_full < -32'sd12288) t_full = -32'sd12288;
  end

  logic [63:0] tsum;
  assign tsum = sq_x_q + sq_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      rep_q <= 1'b0;
      ax_q <= '0; ay_q <= '0; az_q <= '0; ae_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      rep_q <= rep_d;
      if (accept) begin
        ax_q <= nx; ay_q <= ny; az_q <= nz; ae_q <= ne;
      end
      out_v_q <= (state_d == ST_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) sat_q <= sat_x | sat_y | sat_z | sat_e;
    if (state_q == ST_NORM) begin
      ok_q <= ok_c;
      sq_x_q <= ux * ux;
      sq_y_q <= uy * uy;
      ka_q <= msb33(a_sum);
      kb_q <= msb33(b_dif);
      ma_q <= 42'(a_sum) << (6'd40 - msb33(a_sum));
      mb_q <= 42'(b_dif) << (6'd40 - msb33(b_dif));
    end
    if (state_q == ST_CIRC && cnt_q == 5'(Steps)) circ_z_q <= z_ang;
    if (state_q == ST_FINISH) begin
      tsq_q <= tsum[63] ? '1 : tsum[62:0];
      az_out_q <= az_calc;
      rap_q <= ok_q ? t_full[14:0] : '0;
    end
  end

  // Azimuth angle captured after last circular step must include it.
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {sat_q, ok_q, rap_q, az_out_q, tsq_q,
                         ae_q, az_q, ay_q, ax_q};

  `FMK_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni,
                  (state_q == ST_CIRC || state_q == ST_HYP), !s_axis_tready)
  `FMK_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, accept, state_q == ST_NORM)
  `FMK_ASSERT_IMP(a_valid_state, clk_i, rst_ni, m_axis_tvalid, state_q == ST_OUT)
endmodule

[sim/four_momentum_accumulate_kinematics_unit_test.sv]
// Self-checking testbench of the four-momentum accumulate kinematics unit.
`timescale 1ns / 1ps
module four_momentum_accumulate_kinematics_unit_test;

  localparam int unsigned Steps = 16;
  localparam int unsigned CycleLimit = 400000;

  // Members run from the top bit of tdata down to bit 0.
  typedef struct packed {
    logic               saturated;
    logic               rapidity_ok;
    logic signed [14:0] rapidity;
    logic signed [15:0] azimuth;
    logic [62:0]        transverse_sq;
    logic signed [31:0] sum_energy;
    logic signed [31:0] sum_z;
    logic signed [31:0] sum_y;
    logic signed [31:0] sum_x;
  } kinematics_t;

  typedef enum bit {
    CMD_LOAD = 1'b0,
    CMD_ADD  = 1'b1
  } cmd_e;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [223:0] m_axis_tdata;

  four_momentum_accumulate_kinematics_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Arctangent of 2^-i in units of pi/2^20, and atanh of 2^-i in units 2^-16.
  longint circ_atan [24] = '{262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608,
                             1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0, 0, 0, 0};
  longint hyp_atanh [25] = '{0, 35999, 16739, 8235, 4101, 2049, 1024, 512, 256, 128,
                             64, 32, 16, 8, 4, 2, 1, 1, 0, 0, 0, 0, 0, 0, 0};

  longint sum_px, sum_py, sum_pz, sum_pe;
  kinematics_t expected_sums[$];
  int  errors;
  int  cycles;
  int  send_idle_pct;
  int  recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clip32(input longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint azimuth_angle(input longint x, input longint y);
    longint cx, cy, nx, z, a;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x == 0) return (y > 0) ? 16384 : -16384;
    cx = ((x < 0) ? -x : x) <<< 24;
    cy = ((y < 0) ? -y : y) <<< 24;
    for (int i = 0; i < Steps; i++) begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += circ_atan[i];
      end else begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= circ_atan[i];
      end
      cx = nx;
    end
    a = (z + 16) >>> 5;
    if (a < 0) a = 0;
    if (a > 16384) a = 16384;
    if (x > 0) return (y >= 0) ? a : -a;
    return (y >= 0) ? 32768 - a : -(32768 - a);
  endfunction

  function automatic int top_bit(input longint v);
    int k;
    k = 0;
    while (k < 62 && (v >>> (k + 1)) != 0) k++;
    return k;
  endfunction

  // Rapidity in units of 1/1024; the terms E+pz and E-pz are normalized first.
  function automatic longint rapidity_value(input longint pz, input longint e);
    longint a, b, hx, hy, nx, z, t;
    int ka, kb;
    a = e + pz;
    b = e - pz;
    ka = top_bit(a);
    kb = top_bit(b);
    hx = (a <<< (40 - ka)) + (b <<< (40 - kb));
    hy = (a <<< (40 - ka)) - (b <<< (40 - kb));
    z = 0;
    for (int i = 1; i <= Steps; i++) begin
      for (int r = 0; r < ((i == 4 || i == 13) ? 2 : 1); r++) begin
        if (hy < 0) begin
          nx = hx + (hy >>> i);
          hy = hy + (hx >>> i);
          z -= hyp_atanh[i];
        end else begin
          nx = hx - (hy >>> i);
          hy = hy - (hx >>> i);
          z += hyp_atanh[i];
        end
        hx = nx;
      end
    end
    t = ((longint'(ka - kb) * 22713 + z) + 32) >>> 6;
    if (t > 12288) t = 12288;
    if (t < -12288) t = -12288;
    return t;
  endfunction

  // Updates the running sums for one accepted item and returns its kinematics.
  function automatic kinematics_t accumulate(input cmd_e cmd, input logic signed [23:0] px,
                                             input logic signed [23:0] py,
                                             input logic signed [23:0] pz,
                                             input logic signed [23:0] pe);
    kinematics_t k;
    bit clipped;
    longint unsigned ux, uy, tsq;
    clipped = 1'b0;
    if (cmd == CMD_ADD) begin
      sum_px = clip32(sum_px + px, clipped);
      sum_py = clip32(sum_py + py, clipped);
      sum_pz = clip32(sum_pz + pz, clipped);
      sum_pe = clip32(sum_pe + pe, clipped);
    end else begin
      sum_px = px;
      sum_py = py;
      sum_pz = pz;
      sum_pe = pe;
    end
    ux = (sum_px < 0) ? -sum_px : sum_px;
    uy = (sum_py < 0) ? -sum_py : sum_py;
    tsq = ux * ux + uy * uy;
    if (tsq > 64'h7FFF_FFFF_FFFF_FFFF) tsq = 64'h7FFF_FFFF_FFFF_FFFF;
    k.sum_x = sum_px[31:0];
    k.sum_y = sum_py[31:0];
    k.sum_z = sum_pz[31:0];
    k.sum_energy = sum_pe[31:0];
    k.transverse_sq = tsq[62:0];
    k.azimuth = 16'(azimuth_angle(sum_px, sum_py));
    k.rapidity_ok = (sum_pe > sum_pz) && (sum_pe + sum_pz > 0);
    k.rapidity = k.rapidity_ok ? 15'(rapidity_value(sum_pz, sum_pe)) : '0;
    k.saturated = clipped;
    return k;
  endfunction

  // Offers one item, with an optional random gap first, and waits for its transfer.
  task automatic send_item(input cmd_e cmd, input logic [23:0] px, input logic [23:0] py,
                           input logic [23:0] pz, input logic [23:0] pe);
    kinematics_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, pe, pz, py, px, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    item = accumulate(cmd, px, py, pz, pe);
    expected_sums = {expected_sums, item};
  endtask

  function automatic logic [23:0] random_momentum();
    case ($urandom_range(4))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(2000)) - 1000);
      2: return $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
      3: return 24'd0;
      default: return 24'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic test_directed();
    send_item(CMD_LOAD, 24'd0, 24'd0, 24'd0, 24'd0);             // origin
    send_item(CMD_LOAD, 24'd5, 24'd0, 24'd0, 24'd10);            // positive x axis
    send_item(CMD_LOAD, -24'sd5, 24'd0, 24'd3, 24'd3);           // negative x axis, E = pz
    send_item(CMD_LOAD, 24'd0, 24'd7, -24'sd4, 24'd4);           // positive y only, E+pz = 0
    send_item(CMD_LOAD, 24'd0, -24'sd7, 24'd1, 24'd100);         // negative y only
    send_item(CMD_LOAD, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF);
    send_item(CMD_LOAD, 24'h80_0000, 24'h80_0000, 24'h80_0000, 24'h80_0000);
    send_item(CMD_ADD, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF);
    send_item(CMD_LOAD, 24'd3, -24'sd4, 24'h7F_FFFE, 24'h7F_FFFF); // extreme rapidity
    send_item(CMD_LOAD, 24'd3, 24'd4, 24'h80_0001, 24'h7F_FFFF);   // E+pz = 0, so no valid rapidity
    send_item(CMD_ADD, -24'sd1, 24'd1, 24'd0, -24'sd1);
    send_item(CMD_LOAD, -24'sd9, -24'sd9, 24'd0, -24'sd5);         // negative energy
    send_item(CMD_ADD, 24'd9, 24'd9, 24'd5, 24'd5);
  endtask

  // Long runs of extreme adds drive every sum into its 32-bit bound.
  task automatic test_saturation();
    send_item(CMD_LOAD, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000);
    for (int n = 0; n < 262; n++) begin
      send_item(CMD_ADD, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000);
    end
    for (int n = 0; n < 4; n++) begin
      send_item(CMD_ADD, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF);
    end
  endtask

  // Mostly a load followed by a run of adds, with stray adds mixed in.
  task automatic test_random(input int count);
    int sent;
    int run;
    sent = 0;
    while (sent < count) begin
      run = $urandom_range(12);
      if ($urandom_range(9) != 0) begin
        send_item(CMD_LOAD, random_momentum(), random_momentum(), random_momentum(),
                  random_momentum());
        sent++;
      end
      for (int n = 0; n < run; n++) begin
        send_item(CMD_ADD, random_momentum(), random_momentum(), random_momentum(),
                  random_momentum());
        sent++;
      end
    end
  endtask

  // Receiver side: random stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    kinematics_t got, want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_sums.size() == 0) begin
        $error("unexpected result transfer %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_sums.pop_front();
        if (got.sum_x !== want.sum_x) begin
          $error("sum_x expected %0d actual %0d", want.sum_x, got.sum_x);
          errors++;
        end
        if (got.sum_y !== want.sum_y) begin
          $error("sum_y expected %0d actual %0d", want.sum_y, got.sum_y);
          errors++;
        end
        if (got.sum_z !== want.sum_z) begin
          $error("sum_z expected %0d actual %0d", want.sum_z, got.sum_z);
          errors++;
        end
        if (got.sum_energy !== want.sum_energy) begin
          $error("sum_energy expected %0d actual %0d", want.sum_energy, got.sum_energy);
          errors++;
        end
        if (got.transverse_sq !== want.transverse_sq) begin
          $error("transverse_sq expected %0d actual %0d", want.transverse_sq,
                 got.transverse_sq);
          errors++;
        end
        if (got.azimuth !== want.azimuth) begin
          $error("azimuth expected %0d actual %0d", want.azimuth, got.azimuth);
          errors++;
        end
        if (got.rapidity !== want.rapidity) begin
          $error("rapidity_out expected %0d actual %0d", want.rapidity, got.rapidity);
          errors++;
        end
        if (got.rapidity_ok !== want.rapidity_ok) begin
          $error("rapidity_ok expected %0d actual %0d", want.rapidity_ok, got.rapidity_ok);
          errors++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated expected %0d actual %0d", want.saturated, got.saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    sum_px = 0;
    sum_py = 0;
    sum_pz = 0;
    sum_pe = 0;
    send_idle_pct = 31;
    recv_idle_pct = 82;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_random(120);
    send_idle_pct = 82;
    recv_idle_pct = 31;
    test_random(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(130);
    s_axis_tvalid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/fmk_pkg.sv
design/fmk_cordic_unit.sv
design/four_momentum_accumulate_kinematics_unit.sv
sim/four_momentum_accumulate_kinematics_unit_test.sv
